>>> rtl/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int DW    = 32;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  localparam logic signed [DW-1:0] EMPTY_MARK = -32'sd1;

  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [1:0]    status;
    logic [CW-1:0] count;
    logic          empty_before;
    logic          empty_after;
  } plan_t;

  function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    begin
      r = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
      return r[AW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/deq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/deq_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_ring (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [1:0]    operation,
  output deq_pkg::plan_t     plan
);

  logic [deq_pkg::AW-1:0] head;
  logic [deq_pkg::AW-1:0] head_next;
  logic [deq_pkg::CW-1:0] count;
  logic [deq_pkg::CW-1:0] count_next;
  logic [deq_pkg::AW-1:0] head_dec;
  logic [deq_pkg::AW-1:0] head_inc;
  logic [deq_pkg::AW-1:0] tail_slot;
  logic [deq_pkg::AW-1:0] tail_after;
  logic                   full;
  logic                   empty;

  assign full  = (count == deq_pkg::CW'(deq_pkg::DEPTH));
  assign empty = (count == '0);

  assign head_dec = (head == '0) ? deq_pkg::AW'(deq_pkg::DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == deq_pkg::AW'(deq_pkg::DEPTH - 1)) ? '0 : head + 1'b1;

  assign tail_slot  = deq_pkg::ring_wrap(deq_pkg::SW'(head) + deq_pkg::SW'(count));
  assign tail_after = deq_pkg::ring_wrap(deq_pkg::SW'(head_next) + deq_pkg::SW'(count_next)
                                         - deq_pkg::SW'(1));

  always_comb begin
    head_next         = head;
    count_next        = count;
    plan.wr_en        = 1'b0;
    plan.wr_addr      = head_dec;
    plan.status       = deq_pkg::ST_OK;
    case (operation)
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          plan.status = deq_pkg::ST_OVERFLOW;
        end else begin
          head_next  = head_dec;
          count_next = count + 1'b1;
          plan.wr_en = 1'b1;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        plan.wr_addr = tail_slot;
        if (full) begin
          plan.status = deq_pkg::ST_OVERFLOW;
        end else begin
          count_next = count + 1'b1;
          plan.wr_en = 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          plan.status = deq_pkg::ST_UNDERFLOW;
        end else begin
          head_next  = head_inc;
          count_next = count - 1'b1;
        end
      end
      default: begin
        if (empty) begin
          plan.status = deq_pkg::ST_UNDERFLOW;
        end else begin
          count_next = count - 1'b1;
        end
      end
    endcase
    plan.count        = count_next;
    plan.empty_before = empty;
    plan.empty_after  = (count_next == '0);
    plan.rd_en        = !empty && !plan.empty_after &&
                        (operation == deq_pkg::OP_POP_FRONT ||
                         operation == deq_pkg::OP_POP_BACK);
    plan.rd_addr      = (operation == deq_pkg::OP_POP_FRONT) ? head_next : tail_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (step) begin
      head  <= head_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of signed 32-bit values kept in a ring of
// deq_pkg::DEPTH slots in a single-port-write, registered-read RAM. Every
// transfer in gives exactly one transfer out with status, popped value,
// front and back values (-1 when empty) and the low five bits of the count.
// Front and back values are cached in registers, so pushes, overflows,
// underflows and pops that empty the queue register their result when
// accepted; any other pop first waits in the read state for the registered
// RAM read of the new front or back entry. One operation is in flight at a
// time; the output register lets a new transfer in while the previous
// result is being taken. No clearing pass is needed after reset.
module double_ended_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          operation,
  input  wire logic signed [31:0]  value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic signed [31:0]       popped_value,
  output logic signed [31:0]       front_value,
  output logic signed [31:0]       back_value,
  output logic [4:0]               entry_count
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                    state;
  logic                    accept;
  logic                    pend_front;
  logic signed [31:0]      front_c;
  logic signed [31:0]      back_c;
  logic [deq_pkg::DW-1:0]  rd_data;
  deq_pkg::plan_t          plan;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  deq_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .operation (operation),
    .plan      (plan)
  );

  deq_ram #(
    .WIDTH (deq_pkg::DW),
    .DEPTH (deq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (accept && plan.wr_en),
    .wr_addr (plan.wr_addr),
    .wr_data (value),
    .rd_en   (accept && plan.rd_en),
    .rd_addr (plan.rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (plan.rd_en) begin
              state <= S_READ;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        S_READ: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= plan.status;
      entry_count  <= 5'(plan.count);
      pend_front   <= (operation == deq_pkg::OP_POP_FRONT);
      popped_value <= '0;
      front_value  <= plan.empty_before ? deq_pkg::EMPTY_MARK : front_c;
      back_value   <= plan.empty_before ? deq_pkg::EMPTY_MARK : back_c;
      if (plan.status == deq_pkg::ST_OK) begin
        case (operation)
          deq_pkg::OP_PUSH_FRONT: begin
            front_c     <= value;
            front_value <= value;
            if (plan.empty_before) begin
              back_c     <= value;
              back_value <= value;
            end
          end
          deq_pkg::OP_PUSH_BACK: begin
            back_c     <= value;
            back_value <= value;
            if (plan.empty_before) begin
              front_c     <= value;
              front_value <= value;
            end
          end
          deq_pkg::OP_POP_FRONT: begin
            popped_value <= front_c;
            front_value  <= deq_pkg::EMPTY_MARK;
            back_value   <= plan.empty_after ? deq_pkg::EMPTY_MARK : back_c;
          end
          default: begin
            popped_value <= back_c;
            back_value   <= deq_pkg::EMPTY_MARK;
            front_value  <= plan.empty_after ? deq_pkg::EMPTY_MARK : front_c;
          end
        endcase
      end
    end
    if (state == S_READ) begin
      if (pend_front) begin
        front_c     <= rd_data;
        front_value <= rd_data;
      end else begin
        back_c     <= rd_data;
        back_value <= rd_data;
      end
    end
  end

  a_read_out_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !out_valid)
    else $error("result register busy during slot read");

  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    accept && plan.rd_en |=> state == S_READ)
    else $error("pop with refill did not enter read state");

  a_read_delivers: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> out_valid && state == S_IDLE)
    else $error("read state did not produce a result");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == deq_pkg::ST_OVERFLOW |-> entry_count == 5'(deq_pkg::DEPTH))
    else $error("overflow reported while not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == deq_pkg::ST_UNDERFLOW |->
      entry_count == 5'd0 && popped_value == 32'sd0)
    else $error("underflow reported with entries held");

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 200;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped;
    logic signed [31:0] front;
    logic signed [31:0] back;
    logic [4:0]         count;
  } deque_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         operation = deq_pkg::OP_PUSH_FRONT;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] popped_value;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic [4:0]         entry_count;

  deque_report_t queue_reports[$];
  int            error_count = 0;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;
  int            hold_serial = 0;

  logic signed [31:0] model_slots [deq_pkg::DEPTH];
  int                 model_head = 0;
  int                 model_fill = 0;

  double_ended_queue dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .popped_value (popped_value),
    .front_value  (front_value),
    .back_value   (back_value),
    .entry_count  (entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("double_ended_queue verification failed");
    $finish;
  end

  function automatic deque_report_t apply_deque_op(input logic [1:0] op,
                                                   input logic signed [31:0] val);
    deque_report_t r;
    r.status = deq_pkg::ST_OK;
    r.popped = '0;
    if (op == deq_pkg::OP_PUSH_FRONT || op == deq_pkg::OP_PUSH_BACK) begin
      if (model_fill >= deq_pkg::DEPTH) begin
        r.status = deq_pkg::ST_OVERFLOW;
      end else if (op == deq_pkg::OP_PUSH_FRONT) begin
        model_head = (model_head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
        model_slots[model_head] = val;
        model_fill++;
      end else begin
        model_slots[(model_head + model_fill) % deq_pkg::DEPTH] = val;
        model_fill++;
      end
    end else begin
      if (model_fill == 0) begin
        r.status = deq_pkg::ST_UNDERFLOW;
      end else if (op == deq_pkg::OP_POP_FRONT) begin
        r.popped = model_slots[model_head];
        model_head = (model_head + 1) % deq_pkg::DEPTH;
        model_fill--;
      end else begin
        r.popped = model_slots[(model_head + model_fill - 1) % deq_pkg::DEPTH];
        model_fill--;
      end
    end
    if (model_fill == 0) begin
      r.front = deq_pkg::EMPTY_MARK;
      r.back  = deq_pkg::EMPTY_MARK;
    end else begin
      r.front = model_slots[model_head];
      r.back  = model_slots[(model_head + model_fill - 1) % deq_pkg::DEPTH];
    end
    r.count = 5'(model_fill);
    return r;
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 15))
      0: v = 32'sh7fffffff;
      1: v = 32'sh80000000;
      2: v = '0;
      3: v = -32'sd1;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_op(input int push_pct);
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
    return $urandom_range(0, 1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic signed [31:0] val);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid  <= 1'b0;
      operation <= 2'($urandom);
      value     <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queue_reports.insert(queue_reports.size(), apply_deque_op(op, val));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (queue_reports.size() != 0);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  // receiver backpressure
  initial begin
    int  run_left;
    int  hold_left;
    int  seen_hold;
    bit  stall_now;
    run_left  = 0;
    hold_left = 0;
    seen_hold = 0;
    stall_now = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_serial != seen_hold) begin
        seen_hold = hold_serial;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(0, 99) < 35);
          if ($urandom_range(0, 99) < 90) run_left = $urandom_range(1, 4);
          else run_left = $urandom_range(15, 50);
        end
        run_left--;
        out_stall <= stall_now;
      end
    end
  end

  always @(posedge clk) begin
    deque_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (queue_reports.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected transfer out: status %0d count %0d", status, entry_count);
      end else begin
        want = queue_reports[0];
        queue_reports.delete(0);
        if (status !== want.status)
          note_mismatch("status", 32'(want.status), 32'(status));
        if (popped_value !== want.popped)
          note_mismatch("popped_value", want.popped, popped_value);
        if (front_value !== want.front)
          note_mismatch("front_value", want.front, front_value);
        if (back_value !== want.back)
          note_mismatch("back_value", want.back, back_value);
        if (entry_count !== want.count)
          note_mismatch("entry_count", 32'(want.count), 32'(entry_count));
      end
    end
  end

  task automatic test_directed();
    send_item(deq_pkg::OP_POP_FRONT, 32'sh12345678);
    send_item(deq_pkg::OP_POP_BACK, -32'sd1);
    send_item(deq_pkg::OP_PUSH_FRONT, 32'sh7fffffff);
    send_item(deq_pkg::OP_PUSH_BACK, 32'sh80000000);
    send_item(deq_pkg::OP_POP_BACK, '0);
    send_item(deq_pkg::OP_POP_FRONT, '0);
    send_item(deq_pkg::OP_PUSH_BACK, -32'sd1);
    send_item(deq_pkg::OP_POP_FRONT, '0);
    for (int i = 0; i < deq_pkg::DEPTH - 2; i++)
      send_item(deq_pkg::OP_PUSH_FRONT, pick_value());
    send_item(deq_pkg::OP_PUSH_BACK, 32'sh80000000);
    send_item(deq_pkg::OP_PUSH_BACK, 32'sh7fffffff);
    send_item(deq_pkg::OP_PUSH_FRONT, 32'sh55555555);
    send_item(deq_pkg::OP_PUSH_BACK, 32'shaaaaaaaa);
  endtask

  task automatic test_random_mix(input int items);
    int bias;
    bias = 50;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: bias = 20;
          1: bias = 50;
          default: bias = 80;
        endcase
      end
      send_item(pick_op(bias), pick_value());
    end
  endtask

  task automatic test_wraparound();
    for (int i = 0; i < 100; i++) begin
      send_item(deq_pkg::OP_PUSH_BACK, pick_value());
      send_item(deq_pkg::OP_POP_FRONT, pick_value());
    end
    for (int i = 0; i < 50; i++) begin
      send_item(deq_pkg::OP_PUSH_FRONT, pick_value());
      send_item(deq_pkg::OP_POP_BACK, pick_value());
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_serial++;
    tx_quiet = 1'b1;
    for (int i = 0; i < 100; i++) send_item(pick_op(70), pick_value());
    tx_quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_quiet_stream();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    test_random_mix(200);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(500);
    test_wraparound();
    test_backpressure();
    test_quiet_stream();
    test_random_mix(224);
    wait_drained();
    repeat (20) @(posedge clk);
    if (queue_reports.size() != 0) begin
      error_count++;
      $display("%0d transfers out never arrived", queue_reports.size());
    end
    if (error_count == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

endmodule

>>> double_ended_queue.f
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ring.sv
rtl/double_ended_queue.sv
bench/testbench.sv
